@@ rtl/core/xml_name_validator_core_macros.svh @@
// Assertion macros for the XML name validator core
`ifndef XML_NAME_VALIDATOR_CORE_MACROS_SVH
`define XML_NAME_VALIDATOR_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define XNV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define XNV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define XNV_ASSERT(lbl, prop, msg)
`define XNV_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/core/xnv_pkg.sv @@
// Shared types and constants for the XML name validator
`timescale 1ns / 1ps
package xnv_pkg;
    localparam int unsigned RangeW = 8;
    localparam logic [RangeW-1:0] BASE_N = 8'd202;
    localparam logic [RangeW-1:0] IDEO_N = 8'd3;
    localparam logic [RangeW-1:0] COMB_N = 8'd95;
    localparam logic [RangeW-1:0] DIGIT_N = 8'd15;
    localparam logic [RangeW-1:0] EXT_N = 8'd11;
    localparam logic [RangeW-1:0] BASE_OFS = 8'd0;
    localparam logic [RangeW-1:0] IDEO_OFS = 8'd202;
    localparam logic [RangeW-1:0] COMB_OFS = 8'd205;
    localparam logic [RangeW-1:0] DIGIT_OFS = 8'd44;
    localparam logic [RangeW-1:0] EXT_OFS = 8'd59;
    localparam logic [15:0] CP_COLON = 16'h003A;
    localparam logic [15:0] CP_UNDER = 16'h005F;
    localparam logic [15:0] CP_DOT = 16'h002E;
    localparam logic [15:0] CP_DASH = 16'h002D;

    typedef struct packed {
        logic [1:0] position_count;
        logic       prefix_still_xml;
        logic       colon_seen;
        logic       name_broken;
    } name_state_t;

    typedef struct packed {
        logic letter;
        logic other;
    } class_hit_t;
endpackage

@@ rtl/core/xnv_range_rom.sv @@
// Class range ROM with a registered read port
`timescale 1ns / 1ps
module xnv_range_rom
    import xnv_pkg::*;
(
    input  logic              clk,
    input  logic              sel_b,
    input  logic [RangeW-1:0] addr,
    output logic [31:0]       data
);
    logic [31:0] rom_a [0:255];
    logic [31:0] rom_b [0:255];
    logic [31:0] data_a_reg;
    logic [31:0] data_b_reg;
    logic        sel_reg;

    always_comb
    begin
        for (int i = 0; i < 256; i++)
        begin
            rom_a[i] = 32'h0;
            rom_b[i] = 32'h0;
        end
        rom_a[0]={16'h0040,16'h005A}; rom_a[1]={16'h0060,16'h007A}; rom_a[2]={16'h00BF,16'h00D6};
        rom_a[3]={16'h00D7,16'h00F6}; rom_a[4]={16'h00F7,16'h00FF}; rom_a[5]={16'h00FF,16'h0131};
        rom_a[6]={16'h0133,16'h013E}; rom_a[7]={16'h0140,16'h0148}; rom_a[8]={16'h0149,16'h017E};
        rom_a[9]={16'h017F,16'h01C3}; rom_a[10]={16'h01CC,16'h01F0}; rom_a[11]={16'h01F3,16'h01F5};
        rom_a[12]={16'h01F9,16'h0217}; rom_a[13]={16'h024F,16'h02A8}; rom_a[14]={16'h02BA,16'h02C1};
        rom_a[15]={16'h0385,16'h0386}; rom_a[16]={16'h0387,16'h038A}; rom_a[17]={16'h038B,16'h038C};
        rom_a[18]={16'h038D,16'h03A1}; rom_a[19]={16'h03A2,16'h03CE}; rom_a[20]={16'h03CF,16'h03D6};
        rom_a[21]={16'h03D9,16'h03DA}; rom_a[22]={16'h03DB,16'h03DC}; rom_a[23]={16'h03DD,16'h03DE};
        rom_a[24]={16'h03DF,16'h03E0}; rom_a[25]={16'h03E1,16'h03F3}; rom_a[26]={16'h0400,16'h040C};
        rom_a[27]={16'h040D,16'h044F}; rom_a[28]={16'h0450,16'h045C}; rom_a[29]={16'h045D,16'h0481};
        rom_a[30]={16'h048F,16'h04C4}; rom_a[31]={16'h04C6,16'h04C8}; rom_a[32]={16'h04CA,16'h04CC};
        rom_a[33]={16'h04CF,16'h04EB}; rom_a[34]={16'h04ED,16'h04F5}; rom_a[35]={16'h04F7,16'h04F9};
        rom_a[36]={16'h0530,16'h0556}; rom_a[37]={16'h0558,16'h0559}; rom_a[38]={16'h0560,16'h0586};
        rom_a[39]={16'h05CF,16'h05EA}; rom_a[40]={16'h05EF,16'h05F2}; rom_a[41]={16'h0620,16'h063A};
        rom_a[42]={16'h0640,16'h064A}; rom_a[43]={16'h0670,16'h06B7}; rom_a[44]={16'h06B9,16'h06BE};
        rom_a[45]={16'h06BF,16'h06CE}; rom_a[46]={16'h06CF,16'h06D3}; rom_a[47]={16'h06D4,16'h06D5};
        rom_a[48]={16'h06E4,16'h06E6}; rom_a[49]={16'h0904,16'h0939}; rom_a[50]={16'h093C,16'h093D};
        rom_a[51]={16'h0957,16'h0961}; rom_a[52]={16'h0984,16'h098C}; rom_a[53]={16'h098E,16'h0990};
        rom_a[54]={16'h0992,16'h09A8}; rom_a[55]={16'h09A9,16'h09B0}; rom_a[56]={16'h09B1,16'h09B2};
        rom_a[57]={16'h09B5,16'h09B9}; rom_a[58]={16'h09DB,16'h09DD}; rom_a[59]={16'h09DE,16'h09E1};
        rom_a[60]={16'h09EF,16'h09F1}; rom_a[61]={16'h0A04,16'h0A0A}; rom_a[62]={16'h0A0E,16'h0A10};
        rom_a[63]={16'h0A12,16'h0A28}; rom_a[64]={16'h0A29,16'h0A30}; rom_a[65]={16'h0A31,16'h0A33};
        rom_a[66]={16'h0A34,16'h0A36}; rom_a[67]={16'h0A37,16'h0A39}; rom_a[68]={16'h0A58,16'h0A5C};
        rom_a[69]={16'h0A5D,16'h0A5E}; rom_a[70]={16'h0A71,16'h0A74}; rom_a[71]={16'h0A84,16'h0A8B};
        rom_a[72]={16'h0A8C,16'h0A8D}; rom_a[73]={16'h0A8E,16'h0A91}; rom_a[74]={16'h0A92,16'h0AA8};
        rom_a[75]={16'h0AA9,16'h0AB0}; rom_a[76]={16'h0AB1,16'h0AB3}; rom_a[77]={16'h0AB4,16'h0AB9};
        rom_a[78]={16'h0ABC,16'h0ABD}; rom_a[79]={16'h0ADF,16'h0AE0}; rom_a[80]={16'h0B04,16'h0B0C};
        rom_a[81]={16'h0B0E,16'h0B10}; rom_a[82]={16'h0B12,16'h0B28}; rom_a[83]={16'h0B29,16'h0B30};
        rom_a[84]={16'h0B31,16'h0B33}; rom_a[85]={16'h0B35,16'h0B39}; rom_a[86]={16'h0B3C,16'h0B3D};
        rom_a[87]={16'h0B5B,16'h0B5D}; rom_a[88]={16'h0B5E,16'h0B61}; rom_a[89]={16'h0B84,16'h0B8A};
        rom_a[90]={16'h0B8D,16'h0B90}; rom_a[91]={16'h0B91,16'h0B95}; rom_a[92]={16'h0B98,16'h0B9A};
        rom_a[93]={16'h0B9B,16'h0B9C}; rom_a[94]={16'h0B9D,16'h0B9F}; rom_a[95]={16'h0BA2,16'h0BA4};
        rom_a[96]={16'h0BA7,16'h0BAA}; rom_a[97]={16'h0BAD,16'h0BB5}; rom_a[98]={16'h0BB6,16'h0BB9};
        rom_a[99]={16'h0C04,16'h0C0C}; rom_a[100]={16'h0C0D,16'h0C10}; rom_a[101]={16'h0C11,16'h0C28};
        rom_a[102]={16'h0C29,16'h0C33}; rom_a[103]={16'h0C34,16'h0C39}; rom_a[104]={16'h0C5F,16'h0C61};
        rom_a[105]={16'h0C84,16'h0C8C}; rom_a[106]={16'h0C8D,16'h0C90}; rom_a[107]={16'h0C91,16'h0CA8};
        rom_a[108]={16'h0CA9,16'h0CB3}; rom_a[109]={16'h0CB4,16'h0CB9}; rom_a[110]={16'h0CDD,16'h0CDE};
        rom_a[111]={16'h0CDF,16'h0CE1}; rom_a[112]={16'h0D04,16'h0D0C}; rom_a[113]={16'h0D0D,16'h0D10};
        rom_a[114]={16'h0D11,16'h0D28}; rom_a[115]={16'h0D29,16'h0D39}; rom_a[116]={16'h0D5F,16'h0D61};
        rom_a[117]={16'h0E00,16'h0E2E}; rom_a[118]={16'h0E2F,16'h0E30}; rom_a[119]={16'h0E31,16'h0E33};
        rom_a[120]={16'h0E3F,16'h0E45}; rom_a[121]={16'h0E80,16'h0E82}; rom_a[122]={16'h0E83,16'h0E84};
        rom_a[123]={16'h0E86,16'h0E88}; rom_a[124]={16'h0E89,16'h0E8A}; rom_a[125]={16'h0E8C,16'h0E8D};
        rom_a[126]={16'h0E93,16'h0E97}; rom_a[127]={16'h0E98,16'h0E9F}; rom_a[128]={16'h0EA0,16'h0EA3};
        rom_a[129]={16'h0EA4,16'h0EA5}; rom_a[130]={16'h0EA6,16'h0EA7}; rom_a[131]={16'h0EA9,16'h0EAB};
        rom_a[132]={16'h0EAC,16'h0EAE}; rom_a[133]={16'h0EAF,16'h0EB0}; rom_a[134]={16'h0EB1,16'h0EB3};
        rom_a[135]={16'h0EBC,16'h0EBD}; rom_a[136]={16'h0EBF,16'h0EC4}; rom_a[137]={16'h0F3F,16'h0F47};
        rom_a[138]={16'h0F48,16'h0F69}; rom_a[139]={16'h109F,16'h10C5}; rom_a[140]={16'h10CF,16'h10F6};
        rom_a[141]={16'h10FF,16'h1100}; rom_a[142]={16'h1101,16'h1103}; rom_a[143]={16'h1104,16'h1107};
        rom_a[144]={16'h1108,16'h1109}; rom_a[145]={16'h110A,16'h110C}; rom_a[146]={16'h110D,16'h1112};
        rom_a[147]={16'h113B,16'h113C}; rom_a[148]={16'h113D,16'h113E}; rom_a[149]={16'h113F,16'h1140};
        rom_a[150]={16'h114B,16'h114C}; rom_a[151]={16'h114D,16'h114E}; rom_a[152]={16'h114F,16'h1150};
        rom_a[153]={16'h1153,16'h1155}; rom_a[154]={16'h1158,16'h1159}; rom_a[155]={16'h115E,16'h1161};
        rom_a[156]={16'h1162,16'h1163}; rom_a[157]={16'h1164,16'h1165}; rom_a[158]={16'h1166,16'h1167};
        rom_a[159]={16'h1168,16'h1169}; rom_a[160]={16'h116C,16'h116E}; rom_a[161]={16'h1171,16'h1173};
        rom_a[162]={16'h1174,16'h1175}; rom_a[163]={16'h119D,16'h119E}; rom_a[164]={16'h11A7,16'h11A8};
        rom_a[165]={16'h11AA,16'h11AB}; rom_a[166]={16'h11AD,16'h11AF}; rom_a[167]={16'h11B6,16'h11B8};
        rom_a[168]={16'h11B9,16'h11BA}; rom_a[169]={16'h11BB,16'h11C2}; rom_a[170]={16'h11EA,16'h11EB};
        rom_a[171]={16'h11EF,16'h11F0}; rom_a[172]={16'h11F8,16'h11F9}; rom_a[173]={16'h1DFF,16'h1E9B};
        rom_a[174]={16'h1E9F,16'h1EF9}; rom_a[175]={16'h1EFF,16'h1F15}; rom_a[176]={16'h1F17,16'h1F1D};
        rom_a[177]={16'h1F1F,16'h1F45}; rom_a[178]={16'h1F47,16'h1F4D}; rom_a[179]={16'h1F4F,16'h1F57};
        rom_a[180]={16'h1F58,16'h1F59}; rom_a[181]={16'h1F5A,16'h1F5B}; rom_a[182]={16'h1F5C,16'h1F5D};
        rom_a[183]={16'h1F5E,16'h1F7D}; rom_a[184]={16'h1F7F,16'h1FB4}; rom_a[185]={16'h1FB5,16'h1FBC};
        rom_a[186]={16'h1FBD,16'h1FBE}; rom_a[187]={16'h1FC1,16'h1FC4}; rom_a[188]={16'h1FC5,16'h1FCC};
        rom_a[189]={16'h1FCF,16'h1FD3}; rom_a[190]={16'h1FD5,16'h1FDB}; rom_a[191]={16'h1FDF,16'h1FEC};
        rom_a[192]={16'h1FF1,16'h1FF4}; rom_a[193]={16'h1FF5,16'h1FFC}; rom_a[194]={16'h2125,16'h2126};
        rom_a[195]={16'h2129,16'h212B}; rom_a[196]={16'h212D,16'h212E}; rom_a[197]={16'h217F,16'h2182};
        rom_a[198]={16'h3040,16'h3094}; rom_a[199]={16'h30A0,16'h30FA}; rom_a[200]={16'h3104,16'h312C};
        rom_a[201]={16'hABFF,16'hD7A3};
        rom_a[202]={16'h3006,16'h3007}; rom_a[203]={16'h3020,16'h3029}; rom_a[204]={16'h4DFF,16'h9FA5};
        rom_a[205]={16'h02FF,16'h0345}; rom_a[206]={16'h035F,16'h0361}; rom_a[207]={16'h0482,16'h0486};
        rom_a[208]={16'h0590,16'h05A1}; rom_a[209]={16'h05A2,16'h05B9}; rom_a[210]={16'h05BA,16'h05BD};
        rom_a[211]={16'h05BE,16'h05BF}; rom_a[212]={16'h05C0,16'h05C2}; rom_a[213]={16'h05C3,16'h05C4};
        rom_a[214]={16'h064A,16'h0652}; rom_a[215]={16'h066F,16'h0670}; rom_a[216]={16'h06D5,16'h06DC};
        rom_a[217]={16'h06DC,16'h06DF}; rom_a[218]={16'h06DF,16'h06E4}; rom_a[219]={16'h06E6,16'h06E8};
        rom_a[220]={16'h06E9,16'h06ED}; rom_a[221]={16'h0900,16'h0903}; rom_a[222]={16'h093B,16'h093C};
        rom_a[223]={16'h093D,16'h094C}; rom_a[224]={16'h094C,16'h094D}; rom_a[225]={16'h0950,16'h0954};
        rom_a[226]={16'h0961,16'h0963}; rom_a[227]={16'h0980,16'h0983}; rom_a[228]={16'h09BB,16'h09BC};
        rom_a[229]={16'h09BD,16'h09BE}; rom_a[230]={16'h09BE,16'h09BF}; rom_a[231]={16'h09BF,16'h09C4};
        rom_a[232]={16'h09C6,16'h09C8}; rom_a[233]={16'h09CA,16'h09CD}; rom_a[234]={16'h09D6,16'h09D7};
        rom_a[235]={16'h09E1,16'h09E3}; rom_a[236]={16'h0A01,16'h0A02}; rom_a[237]={16'h0A3B,16'h0A3C};
        rom_a[238]={16'h0A3D,16'h0A3E}; rom_a[239]={16'h0A3E,16'h0A3F}; rom_a[240]={16'h0A3F,16'h0A42};
        rom_a[241]={16'h0A46,16'h0A48}; rom_a[242]={16'h0A4A,16'h0A4D}; rom_a[243]={16'h0A6F,16'h0A71};
        rom_a[244]={16'h0A80,16'h0A83}; rom_a[245]={16'h0ABB,16'h0ABC}; rom_a[246]={16'h0ABD,16'h0AC5};
        rom_a[247]={16'h0AC6,16'h0AC9}; rom_a[248]={16'h0ACA,16'h0ACD}; rom_a[249]={16'h0B00,16'h0B03};
        rom_a[250]={16'h0B3B,16'h0B3C}; rom_a[251]={16'h0B3D,16'h0B43}; rom_a[252]={16'h0B46,16'h0B48};
        rom_a[253]={16'h0B4A,16'h0B4D}; rom_a[254]={16'h0B55,16'h0B57}; rom_a[255]={16'h0B81,16'h0B83};
        rom_b[0]={16'h0BBD,16'h0BC2}; rom_b[1]={16'h0BC5,16'h0BC8}; rom_b[2]={16'h0BC9,16'h0BCD};
        rom_b[3]={16'h0BD6,16'h0BD7}; rom_b[4]={16'h0C00,16'h0C03}; rom_b[5]={16'h0C3D,16'h0C44};
        rom_b[6]={16'h0C45,16'h0C48}; rom_b[7]={16'h0C49,16'h0C4D}; rom_b[8]={16'h0C54,16'h0C56};
        rom_b[9]={16'h0C81,16'h0C83}; rom_b[10]={16'h0CBD,16'h0CC4}; rom_b[11]={16'h0CC5,16'h0CC8};
        rom_b[12]={16'h0CC9,16'h0CCD}; rom_b[13]={16'h0CD4,16'h0CD6}; rom_b[14]={16'h0D01,16'h0D03};
        rom_b[15]={16'h0D3D,16'h0D43}; rom_b[16]={16'h0D45,16'h0D48}; rom_b[17]={16'h0D49,16'h0D4D};
        rom_b[18]={16'h0D56,16'h0D57}; rom_b[19]={16'h0E30,16'h0E31}; rom_b[20]={16'h0E33,16'h0E3A};
        rom_b[21]={16'h0E46,16'h0E4E}; rom_b[22]={16'h0EB0,16'h0EB1}; rom_b[23]={16'h0EB3,16'h0EB9};
        rom_b[24]={16'h0EBA,16'h0EBC}; rom_b[25]={16'h0EC7,16'h0ECD}; rom_b[26]={16'h0F17,16'h0F19};
        rom_b[27]={16'h0F34,16'h0F35}; rom_b[28]={16'h0F36,16'h0F37}; rom_b[29]={16'h0F38,16'h0F39};
        rom_b[30]={16'h0F3D,16'h0F3E}; rom_b[31]={16'h0F3E,16'h0F3F}; rom_b[32]={16'h0F70,16'h0F84};
        rom_b[33]={16'h0F85,16'h0F8B}; rom_b[34]={16'h0F8F,16'h0F95}; rom_b[35]={16'h0F96,16'h0F97};
        rom_b[36]={16'h0F98,16'h0FAD}; rom_b[37]={16'h0FB0,16'h0FB7}; rom_b[38]={16'h0FB8,16'h0FB9};
        rom_b[39]={16'h20CF,16'h20DC}; rom_b[40]={16'h20E0,16'h20E1}; rom_b[41]={16'h3029,16'h302F};
        rom_b[42]={16'h3098,16'h3099}; rom_b[43]={16'h3099,16'h309A};
        rom_b[44]={16'h002F,16'h0039}; rom_b[45]={16'h065F,16'h0669}; rom_b[46]={16'h06EF,16'h06F9};
        rom_b[47]={16'h0965,16'h096F}; rom_b[48]={16'h09E5,16'h09EF}; rom_b[49]={16'h0A65,16'h0A6F};
        rom_b[50]={16'h0AE5,16'h0AEF}; rom_b[51]={16'h0B65,16'h0B6F}; rom_b[52]={16'h0BE6,16'h0BEF};
        rom_b[53]={16'h0C65,16'h0C6F}; rom_b[54]={16'h0CE5,16'h0CEF}; rom_b[55]={16'h0D65,16'h0D6F};
        rom_b[56]={16'h0E4F,16'h0E59}; rom_b[57]={16'h0ECF,16'h0ED9}; rom_b[58]={16'h0F1F,16'h0F29};
        rom_b[59]={16'h00B7,16'h00B7}; rom_b[60]={16'h02D0,16'h02D0}; rom_b[61]={16'h02D1,16'h02D1};
        rom_b[62]={16'h0387,16'h0387}; rom_b[63]={16'h0640,16'h0640}; rom_b[64]={16'h0E46,16'h0E46};
        rom_b[65]={16'h0EC6,16'h0EC6}; rom_b[66]={16'h3005,16'h3005}; rom_b[67]={16'h3031,16'h3035};
        rom_b[68]={16'h309D,16'h309E}; rom_b[69]={16'h30FC,16'h30FE};
    end

    always_ff @(posedge clk)
    begin
        data_a_reg <= rom_a[addr];
        data_b_reg <= rom_b[addr];
        sel_reg    <= sel_b;
    end

    assign data = sel_reg ? data_b_reg : data_a_reg;
endmodule

@@ rtl/core/xnv_classifier.sv @@
// Binary search of the class range tables in turn for one code point, stopping early on a letter hit
`timescale 1ns / 1ps
module xnv_classifier
    import xnv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [15:0] cp,
    output logic       done,
    output class_hit_t hit
);
    localparam logic [2:0] C_BASE  = 3'd0;
    localparam logic [2:0] C_IDEO  = 3'd1;
    localparam logic [2:0] C_COMB  = 3'd2;
    localparam logic [2:0] C_DIGIT = 3'd3;
    localparam logic [2:0] C_EXT   = 3'd4;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [2:0]        cls_reg, cls_next;
    logic [RangeW-1:0] lo_reg, lo_next;
    logic [RangeW-1:0] cnt_reg, cnt_next;
    logic [RangeW-1:0] half, probe, base_ofs;
    logic              sel_b;
    logic [8:0]        abs_idx;
    class_hit_t        hit_reg, hit_next;
    logic              done_reg, done_next;
    logic [31:0]       rdata;
    logic [15:0]       r_lo, r_hi;
    logic              in_rng, below;

    always_comb
    begin
        unique case (cls_reg)
            C_BASE:  begin base_ofs = BASE_OFS;  sel_b = 1'b0; end
            C_IDEO:  begin base_ofs = IDEO_OFS;  sel_b = 1'b0; end
            C_COMB:  begin base_ofs = COMB_OFS;  sel_b = 1'b0; end
            C_DIGIT: begin base_ofs = DIGIT_OFS; sel_b = 1'b1; end
            default: begin base_ofs = EXT_OFS;   sel_b = 1'b1; end
        endcase
    end

    assign half  = cnt_reg >> 1;
    assign probe = lo_reg + half;
    assign abs_idx = {1'b0, base_ofs} + {1'b0, probe};

    xnv_range_rom u_rom (
        .clk  (clk),
        .sel_b(sel_b && cls_reg != C_COMB ? 1'b1 : abs_idx[8]),
        .addr (abs_idx[7:0]),
        .data (rdata)
    );

    assign r_lo   = rdata[31:16];
    assign r_hi   = rdata[15:0];
    assign in_rng = (r_lo == r_hi) ? (cp == r_lo) : (cp > r_lo && cp <= r_hi);
    assign below  = (r_lo == r_hi) ? (cp < r_lo) : (cp <= r_lo);

    always_comb
    begin
        state_next = state_reg;
        cls_next   = cls_reg;
        lo_next    = lo_reg;
        cnt_next   = cnt_reg;
        hit_next   = hit_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cls_next   = C_BASE;
                    lo_next    = '0;
                    cnt_next   = BASE_N;
                    hit_next   = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_READ;
                if (in_rng || cnt_reg == 8'd1)
                begin
                    if (in_rng)
                    begin
                        if (cls_reg == C_BASE || cls_reg == C_IDEO)
                            hit_next.letter = 1'b1;
                        else
                            hit_next.other = 1'b1;
                    end
                    if (cls_reg == C_EXT || (in_rng && cls_reg == C_IDEO) ||
                        (in_rng && cls_reg == C_BASE))
                    begin
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        cls_next = cls_reg + 3'd1;
                        lo_next  = '0;
                        unique case (cls_reg)
                            C_BASE:  cnt_next = IDEO_N;
                            C_IDEO:  cnt_next = COMB_N;
                            C_COMB:  cnt_next = DIGIT_N;
                            default: cnt_next = EXT_N;
                        endcase
                    end
                end
                else if (below)
                    cnt_next = half;
                else
                begin
                    lo_next  = probe + 8'd1;
                    cnt_next = cnt_reg - half - 8'd1;
                end
                if (state_next == S_READ && cnt_next == '0)
                begin
                    if (cls_reg == C_EXT)
                    begin
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        cls_next = cls_reg + 3'd1;
                        lo_next  = '0;
                        unique case (cls_reg)
                            C_BASE:  cnt_next = IDEO_N;
                            C_IDEO:  cnt_next = COMB_N;
                            C_COMB:  cnt_next = DIGIT_N;
                            default: cnt_next = EXT_N;
                        endcase
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            cls_reg   <= C_BASE;
            lo_reg    <= '0;
            cnt_reg   <= '0;
            hit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cls_reg   <= cls_next;
            lo_reg    <= lo_next;
            cnt_reg   <= cnt_next;
            hit_reg   <= hit_next;
        end
    end

    assign done = done_reg;
    assign hit  = hit_reg;
endmodule

@@ rtl/core/xml_name_validator_core.sv @@
// Top level of the XML name validator
// Result: an accepted item's result waits on the binary search over the range ROMs
// (each probe a read through the registered ROM port, up to 25 probes).
// Flow: one item at a time; the next item is taken only after the search of the last one
// ends, and after a last item only after its result has left, which a stall can delay.
// Reset: rst_n clears the name state and the handshake state at once.
`timescale 1ns / 1ps
`include "xml_name_validator_core_macros.svh"
module xml_name_validator_core
    import xnv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // code_point
    input  logic        s_tlast,   // last_point
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // valid_name, qualified_name, reserved_name, accepted, 0
);
    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_BUSY = 2'd1;
    localparam logic [1:0] T_OUT  = 2'd2;

    logic [1:0]  tstate_reg, tstate_next;
    logic [15:0] cp_reg;
    logic        last_reg;
    name_state_t st_reg, st_next;
    logic [3:0]  res_reg, res_next;
    logic        cls_start, cls_done, ok;
    class_hit_t  hit;

    assign s_tready  = (tstate_reg == T_IDLE);
    assign cls_start = s_tvalid && s_tready;

    xnv_classifier u_cls (
        .clk  (clk),
        .rst_n(rst_n),
        .start(cls_start),
        .cp   (cp_reg),
        .done (cls_done),
        .hit  (hit)
    );

    always_comb
    begin
        if (st_reg.position_count == 2'd0)
            ok = hit.letter || cp_reg == CP_UNDER || cp_reg == CP_COLON;
        else
            ok = hit.letter || hit.other || cp_reg == CP_UNDER || cp_reg == CP_COLON ||
                 cp_reg == CP_DOT || cp_reg == CP_DASH;
    end

    always_comb
    begin
        logic [3:0] r;
        r = '0;
        st_next     = st_reg;
        res_next    = res_reg;
        tstate_next = tstate_reg;
        unique case (tstate_reg)
            T_IDLE: if (cls_start) tstate_next = T_BUSY;
            T_BUSY:
            begin
                if (cls_done)
                begin
                    if (!st_reg.name_broken)
                    begin
                        if (!ok)
                            st_next.name_broken = 1'b1;
                        else
                        begin
                            if (cp_reg == CP_COLON) st_next.colon_seen = 1'b1;
                            unique case (st_reg.position_count)
                                2'd0: st_next.prefix_still_xml =
                                      (cp_reg == 16'h0058 || cp_reg == 16'h0078);
                                2'd1: st_next.prefix_still_xml = st_reg.prefix_still_xml &&
                                      (cp_reg == 16'h004D || cp_reg == 16'h006D);
                                2'd2: st_next.prefix_still_xml = st_reg.prefix_still_xml &&
                                      (cp_reg == 16'h004C || cp_reg == 16'h006C);
                                default: ;
                            endcase
                            if (st_reg.position_count != 2'd3)
                                st_next.position_count = st_reg.position_count + 2'd1;
                        end
                    end
                    if (last_reg)
                    begin
                        r[0] = !st_next.name_broken;
                        r[1] = st_next.colon_seen;
                        r[2] = st_next.prefix_still_xml && st_next.position_count == 2'd3;
                        r[3] = r[0] && !r[1] && !r[2];
                        res_next    = r;
                        st_next     = '0;
                        tstate_next = T_OUT;
                    end
                    else
                        tstate_next = T_IDLE;
                end
            end
            T_OUT: if (m_tready) tstate_next = T_IDLE;
            default: tstate_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cls_start)
        begin
            cp_reg   <= s_tdata;
            last_reg <= s_tlast;
        end
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tstate_reg <= T_IDLE;
            st_reg     <= '0;
        end
        else
        begin
            tstate_reg <= tstate_next;
            st_reg     <= st_next;
        end
    end

    assign m_tvalid = (tstate_reg == T_OUT);
    assign m_tdata  = {4'b0000, res_reg};

    `XNV_ASSERT(a_one_side, !(s_tready && m_tvalid), "input taken while result pending")
    `XNV_ASSERT(a_acc_impl, !m_tvalid || !m_tdata[3] || m_tdata[0], "accepted without valid")
    `XNV_ASSERT_NEXT(a_done_busy, cls_done, tstate_reg != T_BUSY || $past(tstate_reg) == T_BUSY,
        "search done outside busy")
endmodule

@@ bench/xml_name_validator_core_test.sv @@
// Self-checking bench for the XML name validator core: directed and random names
`timescale 1ns / 1ps
class name_flag_board;
    bit [15:0] base_tab[$];
    bit [15:0] ideo_tab[$];
    bit [15:0] comb_tab[$];
    bit [15:0] digit_tab[$];
    bit [15:0] ext_tab[$];
    bit [1:0] pos_cnt;
    bit xml_prefix;
    bit colon_hit;
    bit broken;
    bit [3:0] flags_due[$];
    int errors;

    function new();
        base_tab = '{
            16'h0040,16'h005A, 16'h0060,16'h007A, 16'h00BF,16'h00D6, 16'h00D7,16'h00F6,
            16'h00F7,16'h00FF, 16'h00FF,16'h0131, 16'h0133,16'h013E, 16'h0140,16'h0148,
            16'h0149,16'h017E, 16'h017F,16'h01C3, 16'h01CC,16'h01F0, 16'h01F3,16'h01F5,
            16'h01F9,16'h0217, 16'h024F,16'h02A8, 16'h02BA,16'h02C1, 16'h0385,16'h0386,
            16'h0387,16'h038A, 16'h038B,16'h038C, 16'h038D,16'h03A1, 16'h03A2,16'h03CE,
            16'h03CF,16'h03D6, 16'h03D9,16'h03DA, 16'h03DB,16'h03DC, 16'h03DD,16'h03DE,
            16'h03DF,16'h03E0, 16'h03E1,16'h03F3, 16'h0400,16'h040C, 16'h040D,16'h044F,
            16'h0450,16'h045C, 16'h045D,16'h0481, 16'h048F,16'h04C4, 16'h04C6,16'h04C8,
            16'h04CA,16'h04CC, 16'h04CF,16'h04EB, 16'h04ED,16'h04F5, 16'h04F7,16'h04F9,
            16'h0530,16'h0556, 16'h0558,16'h0559, 16'h0560,16'h0586, 16'h05CF,16'h05EA,
            16'h05EF,16'h05F2, 16'h0620,16'h063A, 16'h0640,16'h064A, 16'h0670,16'h06B7,
            16'h06B9,16'h06BE, 16'h06BF,16'h06CE, 16'h06CF,16'h06D3, 16'h06D4,16'h06D5,
            16'h06E4,16'h06E6, 16'h0904,16'h0939, 16'h093C,16'h093D, 16'h0957,16'h0961,
            16'h0984,16'h098C, 16'h098E,16'h0990, 16'h0992,16'h09A8, 16'h09A9,16'h09B0,
            16'h09B1,16'h09B2, 16'h09B5,16'h09B9, 16'h09DB,16'h09DD, 16'h09DE,16'h09E1,
            16'h09EF,16'h09F1, 16'h0A04,16'h0A0A, 16'h0A0E,16'h0A10, 16'h0A12,16'h0A28,
            16'h0A29,16'h0A30, 16'h0A31,16'h0A33, 16'h0A34,16'h0A36, 16'h0A37,16'h0A39,
            16'h0A58,16'h0A5C, 16'h0A5D,16'h0A5E, 16'h0A71,16'h0A74, 16'h0A84,16'h0A8B,
            16'h0A8C,16'h0A8D, 16'h0A8E,16'h0A91, 16'h0A92,16'h0AA8, 16'h0AA9,16'h0AB0,
            16'h0AB1,16'h0AB3, 16'h0AB4,16'h0AB9, 16'h0ABC,16'h0ABD, 16'h0ADF,16'h0AE0,
            16'h0B04,16'h0B0C, 16'h0B0E,16'h0B10, 16'h0B12,16'h0B28, 16'h0B29,16'h0B30,
            16'h0B31,16'h0B33, 16'h0B35,16'h0B39, 16'h0B3C,16'h0B3D, 16'h0B5B,16'h0B5D,
            16'h0B5E,16'h0B61, 16'h0B84,16'h0B8A, 16'h0B8D,16'h0B90, 16'h0B91,16'h0B95,
            16'h0B98,16'h0B9A, 16'h0B9B,16'h0B9C, 16'h0B9D,16'h0B9F, 16'h0BA2,16'h0BA4,
            16'h0BA7,16'h0BAA, 16'h0BAD,16'h0BB5, 16'h0BB6,16'h0BB9, 16'h0C04,16'h0C0C,
            16'h0C0D,16'h0C10, 16'h0C11,16'h0C28, 16'h0C29,16'h0C33, 16'h0C34,16'h0C39,
            16'h0C5F,16'h0C61, 16'h0C84,16'h0C8C, 16'h0C8D,16'h0C90, 16'h0C91,16'h0CA8,
            16'h0CA9,16'h0CB3, 16'h0CB4,16'h0CB9, 16'h0CDD,16'h0CDE, 16'h0CDF,16'h0CE1,
            16'h0D04,16'h0D0C, 16'h0D0D,16'h0D10, 16'h0D11,16'h0D28, 16'h0D29,16'h0D39,
            16'h0D5F,16'h0D61, 16'h0E00,16'h0E2E, 16'h0E2F,16'h0E30, 16'h0E31,16'h0E33,
            16'h0E3F,16'h0E45, 16'h0E80,16'h0E82, 16'h0E83,16'h0E84, 16'h0E86,16'h0E88,
            16'h0E89,16'h0E8A, 16'h0E8C,16'h0E8D, 16'h0E93,16'h0E97, 16'h0E98,16'h0E9F,
            16'h0EA0,16'h0EA3, 16'h0EA4,16'h0EA5, 16'h0EA6,16'h0EA7, 16'h0EA9,16'h0EAB,
            16'h0EAC,16'h0EAE, 16'h0EAF,16'h0EB0, 16'h0EB1,16'h0EB3, 16'h0EBC,16'h0EBD,
            16'h0EBF,16'h0EC4, 16'h0F3F,16'h0F47, 16'h0F48,16'h0F69, 16'h109F,16'h10C5,
            16'h10CF,16'h10F6, 16'h10FF,16'h1100, 16'h1101,16'h1103, 16'h1104,16'h1107,
            16'h1108,16'h1109, 16'h110A,16'h110C, 16'h110D,16'h1112, 16'h113B,16'h113C,
            16'h113D,16'h113E, 16'h113F,16'h1140, 16'h114B,16'h114C, 16'h114D,16'h114E,
            16'h114F,16'h1150, 16'h1153,16'h1155, 16'h1158,16'h1159, 16'h115E,16'h1161,
            16'h1162,16'h1163, 16'h1164,16'h1165, 16'h1166,16'h1167, 16'h1168,16'h1169,
            16'h116C,16'h116E, 16'h1171,16'h1173, 16'h1174,16'h1175, 16'h119D,16'h119E,
            16'h11A7,16'h11A8, 16'h11AA,16'h11AB, 16'h11AD,16'h11AF, 16'h11B6,16'h11B8,
            16'h11B9,16'h11BA, 16'h11BB,16'h11C2, 16'h11EA,16'h11EB, 16'h11EF,16'h11F0,
            16'h11F8,16'h11F9, 16'h1DFF,16'h1E9B, 16'h1E9F,16'h1EF9, 16'h1EFF,16'h1F15,
            16'h1F17,16'h1F1D, 16'h1F1F,16'h1F45, 16'h1F47,16'h1F4D, 16'h1F4F,16'h1F57,
            16'h1F58,16'h1F59, 16'h1F5A,16'h1F5B, 16'h1F5C,16'h1F5D, 16'h1F5E,16'h1F7D,
            16'h1F7F,16'h1FB4, 16'h1FB5,16'h1FBC, 16'h1FBD,16'h1FBE, 16'h1FC1,16'h1FC4,
            16'h1FC5,16'h1FCC, 16'h1FCF,16'h1FD3, 16'h1FD5,16'h1FDB, 16'h1FDF,16'h1FEC,
            16'h1FF1,16'h1FF4, 16'h1FF5,16'h1FFC, 16'h2125,16'h2126, 16'h2129,16'h212B,
            16'h212D,16'h212E, 16'h217F,16'h2182, 16'h3040,16'h3094, 16'h30A0,16'h30FA,
            16'h3104,16'h312C, 16'hABFF,16'hD7A3};
        ideo_tab = '{16'h3006,16'h3007, 16'h3020,16'h3029, 16'h4DFF,16'h9FA5};
        comb_tab = '{
            16'h02FF,16'h0345, 16'h035F,16'h0361, 16'h0482,16'h0486, 16'h0590,16'h05A1,
            16'h05A2,16'h05B9, 16'h05BA,16'h05BD, 16'h05BE,16'h05BF, 16'h05C0,16'h05C2,
            16'h05C3,16'h05C4, 16'h064A,16'h0652, 16'h066F,16'h0670, 16'h06D5,16'h06DC,
            16'h06DC,16'h06DF, 16'h06DF,16'h06E4, 16'h06E6,16'h06E8, 16'h06E9,16'h06ED,
            16'h0900,16'h0903, 16'h093B,16'h093C, 16'h093D,16'h094C, 16'h094C,16'h094D,
            16'h0950,16'h0954, 16'h0961,16'h0963, 16'h0980,16'h0983, 16'h09BB,16'h09BC,
            16'h09BD,16'h09BE, 16'h09BE,16'h09BF, 16'h09BF,16'h09C4, 16'h09C6,16'h09C8,
            16'h09CA,16'h09CD, 16'h09D6,16'h09D7, 16'h09E1,16'h09E3, 16'h0A01,16'h0A02,
            16'h0A3B,16'h0A3C, 16'h0A3D,16'h0A3E, 16'h0A3E,16'h0A3F, 16'h0A3F,16'h0A42,
            16'h0A46,16'h0A48, 16'h0A4A,16'h0A4D, 16'h0A6F,16'h0A71, 16'h0A80,16'h0A83,
            16'h0ABB,16'h0ABC, 16'h0ABD,16'h0AC5, 16'h0AC6,16'h0AC9, 16'h0ACA,16'h0ACD,
            16'h0B00,16'h0B03, 16'h0B3B,16'h0B3C, 16'h0B3D,16'h0B43, 16'h0B46,16'h0B48,
            16'h0B4A,16'h0B4D, 16'h0B55,16'h0B57, 16'h0B81,16'h0B83, 16'h0BBD,16'h0BC2,
            16'h0BC5,16'h0BC8, 16'h0BC9,16'h0BCD, 16'h0BD6,16'h0BD7, 16'h0C00,16'h0C03,
            16'h0C3D,16'h0C44, 16'h0C45,16'h0C48, 16'h0C49,16'h0C4D, 16'h0C54,16'h0C56,
            16'h0C81,16'h0C83, 16'h0CBD,16'h0CC4, 16'h0CC5,16'h0CC8, 16'h0CC9,16'h0CCD,
            16'h0CD4,16'h0CD6, 16'h0D01,16'h0D03, 16'h0D3D,16'h0D43, 16'h0D45,16'h0D48,
            16'h0D49,16'h0D4D, 16'h0D56,16'h0D57, 16'h0E30,16'h0E31, 16'h0E33,16'h0E3A,
            16'h0E46,16'h0E4E, 16'h0EB0,16'h0EB1, 16'h0EB3,16'h0EB9, 16'h0EBA,16'h0EBC,
            16'h0EC7,16'h0ECD, 16'h0F17,16'h0F19, 16'h0F34,16'h0F35, 16'h0F36,16'h0F37,
            16'h0F38,16'h0F39, 16'h0F3D,16'h0F3E, 16'h0F3E,16'h0F3F, 16'h0F70,16'h0F84,
            16'h0F85,16'h0F8B, 16'h0F8F,16'h0F95, 16'h0F96,16'h0F97, 16'h0F98,16'h0FAD,
            16'h0FB0,16'h0FB7, 16'h0FB8,16'h0FB9, 16'h20CF,16'h20DC, 16'h20E0,16'h20E1,
            16'h3029,16'h302F, 16'h3098,16'h3099, 16'h3099,16'h309A};
        digit_tab = '{
            16'h002F,16'h0039, 16'h065F,16'h0669, 16'h06EF,16'h06F9, 16'h0965,16'h096F,
            16'h09E5,16'h09EF, 16'h0A65,16'h0A6F, 16'h0AE5,16'h0AEF, 16'h0B65,16'h0B6F,
            16'h0BE6,16'h0BEF, 16'h0C65,16'h0C6F, 16'h0CE5,16'h0CEF, 16'h0D65,16'h0D6F,
            16'h0E4F,16'h0E59, 16'h0ECF,16'h0ED9, 16'h0F1F,16'h0F29};
        ext_tab = '{
            16'h00B7,16'h00B7, 16'h02D0,16'h02D0, 16'h02D1,16'h02D1, 16'h0387,16'h0387,
            16'h0640,16'h0640, 16'h0E46,16'h0E46, 16'h0EC6,16'h0EC6, 16'h3005,16'h3005,
            16'h3031,16'h3035, 16'h309D,16'h309E, 16'h30FC,16'h30FE};
        errors = 0;
        clear_name();
    endfunction

    function void clear_name();
        pos_cnt = 0;
        xml_prefix = 0;
        colon_hit = 0;
        broken = 0;
    endfunction

    function bit in_ranges(ref bit [15:0] tab[$], input bit [15:0] cp);
        for (int k = 0; k + 1 < tab.size(); k += 2)
        begin
            if (tab[k] == tab[k+1])
            begin
                if (cp == tab[k])
                    return 1;
            end
            else if (cp > tab[k] && cp <= tab[k+1])
                return 1;
        end
        return 0;
    endfunction

    function bit letter_hit(bit [15:0] cp);
        return in_ranges(base_tab, cp) || in_ranges(ideo_tab, cp);
    endfunction

    function bit namechar_hit(bit [15:0] cp);
        return letter_hit(cp) || in_ranges(digit_tab, cp) || in_ranges(comb_tab, cp)
            || in_ranges(ext_tab, cp) || cp == xnv_pkg::CP_DOT || cp == xnv_pkg::CP_DASH
            || cp == xnv_pkg::CP_UNDER || cp == xnv_pkg::CP_COLON;
    endfunction

    function void note_point(bit [15:0] cp, bit last);
        bit ok;
        bit valid;
        bit rsv;
        if (!broken)
        begin
            if (pos_cnt == 0)
                ok = letter_hit(cp) || cp == xnv_pkg::CP_UNDER || cp == xnv_pkg::CP_COLON;
            else
                ok = namechar_hit(cp);
            if (!ok)
                broken = 1;
            else
            begin
                if (cp == xnv_pkg::CP_COLON)
                    colon_hit = 1;
                case (pos_cnt)
                    2'd0: xml_prefix = (cp == 16'h0058 || cp == 16'h0078);
                    2'd1: xml_prefix = xml_prefix && (cp == 16'h004D || cp == 16'h006D);
                    2'd2: xml_prefix = xml_prefix && (cp == 16'h004C || cp == 16'h006C);
                    default: ;
                endcase
                if (pos_cnt < 3)
                    pos_cnt++;
            end
        end
        if (last)
        begin
            valid = !broken;
            rsv = xml_prefix && pos_cnt == 3;
            flags_due.push_back({valid, colon_hit, rsv, valid && !colon_hit && !rsv});
            clear_name();
        end
    endfunction

    function void check_flags(bit [7:0] got);
        bit [3:0] want;
        bit [3:0] seen;
        seen = {got[0], got[1], got[2], got[3]};
        if (flags_due.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
            return;
        end
        want = flags_due.pop_front();
        if (got[7:4] != 0)
        begin
            $display("%0t: pad bits expected 0, actual %h", $time, got[7:4]);
            errors++;
        end
        if (seen[3] != want[3])
        begin
            $display("%0t: valid_name expected %b, actual %b", $time, want[3], seen[3]);
            errors++;
        end
        if (seen[2] != want[2])
        begin
            $display("%0t: qualified_name expected %b, actual %b", $time, want[2], seen[2]);
            errors++;
        end
        if (seen[1] != want[1])
        begin
            $display("%0t: reserved_name expected %b, actual %b", $time, want[1], seen[1]);
            errors++;
        end
        if (seen[0] != want[0])
        begin
            $display("%0t: accepted expected %b, actual %b", $time, want[0], seen[0]);
            errors++;
        end
    endfunction
endclass

module xml_name_validator_core_test;
    import xnv_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;

    name_flag_board board;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;

    localparam int QUIET_LIMIT = 20000;

    xml_name_validator_core DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_flags(m_tdata);
        if (rst_n && ((s_tvalid && s_tready) || (m_tvalid && m_tready)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_point(input bit [15:0] cp, input bit last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= cp;
        s_tlast <= last;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_point(cp, last);
        @(negedge clk);
    endtask

    task automatic send_name(input bit [15:0] pts[$]);
        foreach (pts[k])
            send_point(pts[k], k == pts.size() - 1);
    endtask

    function automatic bit [15:0] pick_start();
        case ($urandom_range(5))
            0: return CP_UNDER;
            1: return CP_COLON;
            2: return 16'(16'h0041 + $urandom_range(25));
            3: return 16'(16'h4E00 + $urandom_range(16'h51A5));
            4: return 16'(16'hAC00 + $urandom_range(16'h2BA3));
            default: return 16'(16'h0061 + $urandom_range(25));
        endcase
    endfunction

    function automatic bit [15:0] pick_char();
        case ($urandom_range(9))
            0: return 16'(16'h0030 + $urandom_range(9));
            1: return CP_DOT;
            2: return CP_DASH;
            3: return 16'h00B7;
            4: return 16'(16'h0300 + $urandom_range(16'h45));
            5: return 16'(16'h30FC + $urandom_range(2));
            6: return CP_COLON;
            default: return pick_start();
        endcase
    endfunction

    function automatic bit [15:0] xml_letter(int idx);
        bit [15:0] up;
        up = (idx == 0) ? 16'h0058 : (idx == 1) ? 16'h004D : 16'h004C;
        return $urandom_range(1) ? up : (up | 16'h0020);
    endfunction

    task automatic random_names(input int n_points);
        bit [15:0] pts[$];
        int len;
        int kind;
        int sent;
        sent = 0;
        while (sent < n_points)
        begin
            pts.delete();
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(6, 1);
            kind = $urandom_range(9);
            for (int k = 0; k < len; k++)
            begin
                if (kind <= 1 && k < 3)
                    pts.push_back(xml_letter(k));
                else if (kind >= 8)
                    pts.push_back(16'($urandom_range(16'hFFFF)));
                else if (k == 0)
                    pts.push_back(pick_start());
                else
                    pts.push_back(pick_char());
            end
            if (kind == 7)
                pts[$urandom_range(len - 1)] = 16'($urandom_range(16'hFFFF));
            send_name(pts);
            sent += len;
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input int n_points);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        random_names(n_points);
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_name('{16'h0000});
        send_name('{16'hFFFF});
        send_name('{CP_COLON});
        send_name('{CP_UNDER});
        send_name('{16'h0041});
        send_name('{16'h0040});
        send_name('{16'h0078, 16'h004D, 16'h006C});
        send_name('{16'h0058, 16'h006D, 16'h004C, 16'h0031});
        send_name('{16'h0078, 16'h006D});
        send_name('{16'h0078, 16'h006D, 16'h006C, 16'h0021, 16'h0061});
        send_name('{16'h0061, CP_COLON, 16'h0062});
        send_name('{16'h0031, CP_COLON});
        send_name('{16'h0061, CP_DOT, CP_DASH, 16'h00B7, 16'h0301, 16'h3005});
        send_name('{16'h4E00, 16'h9FA5, 16'hD7A3, 16'hABFF});

        run_phase(0, 0, 390);
        run_phase(69, 0, 370);
        run_phase(0, 69, 370);
        run_phase(29, 29, 370);

        s_tvalid <= 1'b0;
        while (board.flags_due.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/xnv_pkg.sv
rtl/core/xnv_range_rom.sv
rtl/core/xnv_classifier.sv
rtl/core/xml_name_validator_core.sv
bench/xml_name_validator_core_test.sv
